// ===== hw/rtl/qpr_pkg.sv =====
// Shared types, widths and helpers for the quaternion product/rotation unit.
// No dependencies.
`default_nettype none

package qpr_pkg;

  // Q16.16 format
  localparam int unsigned FRAC  = 16;
  localparam int unsigned Q_W   = 32;
  // 32-bit operand times 33-bit operand (conjugate needs one extra bit)
  localparam int unsigned OPB_W = Q_W + 1;
  localparam int unsigned MUL_W = Q_W + OPB_W;
  // shifted term, then four-term sum
  localparam int unsigned TERM_W = MUL_W - FRAC;
  localparam int unsigned SUM_W  = TERM_W + 2;

  // quaternion component slots
  localparam int C_W = 0;
  localparam int C_X = 1;
  localparam int C_Y = 2;
  localparam int C_Z = 3;

  // request commands
  localparam logic CMD_PROD = 1'b0;
  localparam logic CMD_ROT  = 1'b1;

  typedef logic signed [Q_W-1:0]   q32_t;
  typedef logic signed [OPB_W-1:0] q33_t;
  typedef logic signed [MUL_W-1:0] mul_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic cmd;
    q32_t a_w;
    q32_t a_x;
    q32_t a_y;
    q32_t a_z;
    q32_t b_w;
    q32_t b_x;
    q32_t b_y;
    q32_t b_z;
  } req_t;

  typedef struct packed {
    q32_t r_w;
    q32_t r_x;
    q32_t r_y;
    q32_t r_z;
  } rsp_t;

  localparam sum_t SAT_HI = sum_t'(32'sh7FFF_FFFF);
  localparam sum_t SAT_LO = sum_t'(32'sh8000_0000);

  // product truncated toward minus infinity, widened for summing
  function automatic sum_t fterm(mul_t p);
    mul_t sh;
    sh = p >>> FRAC;
    return sh[SUM_W-1:0];
  endfunction

  function automatic q32_t sat32(sum_t s);
    sum_t c;
    if (s > SAT_HI) begin
      c = SAT_HI;
    end else if (s < SAT_LO) begin
      c = SAT_LO;
    end else begin
      c = s;
    end
    return c[Q_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/qpr_mul_stage.sv =====
// Product stage: all sixteen cross products p_i * q_j, registered.
// Depends on qpr_pkg.
`default_nettype none

module qpr_mul_stage import qpr_pkg::*; (
  input  wire logic clk_i,
  input  wire logic en_i,
  input  wire q32_t p_i [4],
  input  wire q33_t q_i [4],
  output mul_t      prod_o [4][4]
);

  mul_t prod_q [4][4];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          prod_q[i][j] <= MUL_W'(p_i[i]) * MUL_W'(q_i[j]);
        end
      end
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

// ===== hw/rtl/qpr_sum_stage.sv =====
// Sum stage: Hamilton combination of shifted products, saturate, register.
// Optional bypass loads a ready result instead. Depends on qpr_pkg.
`default_nettype none

module qpr_sum_stage import qpr_pkg::*; (
  input  wire logic clk_i,
  input  wire logic en_i,
  input  wire mul_t prod_i [4][4],
  input  wire logic byp_en_i,
  input  wire q32_t byp_i [4],
  output q32_t      r_o [4]
);

  sum_t t [4][4];
  sum_t s [4];
  q32_t r_q [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        t[i][j] = fterm(prod_i[i][j]);
      end
    end
    s[C_W] = t[C_W][C_W] - t[C_X][C_X] - t[C_Y][C_Y] - t[C_Z][C_Z];
    s[C_X] = t[C_W][C_X] + t[C_X][C_W] + t[C_Y][C_Z] - t[C_Z][C_Y];
    s[C_Y] = t[C_W][C_Y] + t[C_Y][C_W] + t[C_Z][C_X] - t[C_X][C_Z];
    s[C_Z] = t[C_W][C_Z] + t[C_Z][C_W] + t[C_X][C_Y] - t[C_Y][C_X];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 4; k++) begin
        r_q[k] <= byp_en_i ? byp_i[k] : sat32(s[k]);
      end
    end
  end

  assign r_o = r_q;

endmodule

`default_nettype wire

// ===== hw/rtl/quaternion_product_rotate.sv =====
// Top level of the quaternion product/rotation unit: four-stage pipeline.
// Depends on qpr_pkg, qpr_mul_stage, qpr_sum_stage.
//
// Takes one request per cycle while in_ready_o is high and returns one result
// per request, in order, from the stage-4 output register. Signed Q16.16
// throughout. cmd 0 gives the Hamilton product a*b; cmd 1 gives the rotation
// a*b*conj(a) (zero b_w and read r_x..r_z to rotate a vector). Each product
// is truncated toward minus infinity, each component sum saturates to 32
// bits, and for cmd 1 the intermediate a*b is saturated the same way before
// the second product. Stages: (1) sixteen 32x33 multiplies of a and b,
// (2) sum and saturate, (3) sixteen multiplies of that result by conj(a),
// (4) sum and saturate, or pass the stage-2 result on for cmd 0. Stage 4 is
// the output register. Every stage holds a valid bit and moves on when the
// stage after it is empty or moving, so bubbles close up under a stalled
// output and in_ready_o stays high until all four stages are full.
`default_nettype none

module quaternion_product_rotate import qpr_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire req_t in_req_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output rsp_t      out_rsp_o
);

  // stage valids and advance enables
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4 = !v4_q || out_ready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign in_ready_o  = en1;
  assign out_valid_o = v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // operands of the first product
  q32_t a_in [4];
  q33_t b_in [4];

  assign a_in[C_W] = in_req_i.a_w;
  assign a_in[C_X] = in_req_i.a_x;
  assign a_in[C_Y] = in_req_i.a_y;
  assign a_in[C_Z] = in_req_i.a_z;
  assign b_in[C_W] = OPB_W'(in_req_i.b_w);
  assign b_in[C_X] = OPB_W'(in_req_i.b_x);
  assign b_in[C_Y] = OPB_W'(in_req_i.b_y);
  assign b_in[C_Z] = OPB_W'(in_req_i.b_z);

  // sideband travelling with the item: command, a, and the a*b bypass
  logic cmd_q1, cmd_q2, cmd_q3;
  q32_t a_q1 [4];
  q32_t a_q2 [4];
  q32_t byp_q3 [4];

  mul_t prod1 [4][4];
  mul_t prod2 [4][4];
  q32_t r1 [4];
  q32_t r2 [4];
  q33_t conj_a [4];
  q32_t zero_q [4];

  assign zero_q = '{default: '0};

  // conjugate in 33 bits so -(-2^31) stays exact
  assign conj_a[C_W] = OPB_W'(a_q2[C_W]);
  assign conj_a[C_X] = -OPB_W'(a_q2[C_X]);
  assign conj_a[C_Y] = -OPB_W'(a_q2[C_Y]);
  assign conj_a[C_Z] = -OPB_W'(a_q2[C_Z]);

  always_ff @(posedge clk_i) begin
    if (en1) begin
      cmd_q1 <= in_req_i.cmd;
      a_q1   <= a_in;
    end
    if (en2) begin
      cmd_q2 <= cmd_q1;
      a_q2   <= a_q1;
    end
    if (en3) begin
      cmd_q3 <= cmd_q2;
      byp_q3 <= r1;
    end
  end

  // stage 1: a * b products
  qpr_mul_stage u_mul1 (
    .clk_i  (clk_i),
    .en_i   (en1),
    .p_i    (a_in),
    .q_i    (b_in),
    .prod_o (prod1)
  );

  // stage 2: a*b, saturated
  qpr_sum_stage u_sum1 (
    .clk_i    (clk_i),
    .en_i     (en2),
    .prod_i   (prod1),
    .byp_en_i (1'b0),
    .byp_i    (zero_q),
    .r_o      (r1)
  );

  // stage 3: (a*b) * conj(a) products
  qpr_mul_stage u_mul2 (
    .clk_i  (clk_i),
    .en_i   (en3),
    .p_i    (r1),
    .q_i    (conj_a),
    .prod_o (prod2)
  );

  // stage 4: rotation result, or a*b passed through for the product request
  qpr_sum_stage u_sum2 (
    .clk_i    (clk_i),
    .en_i     (en4),
    .prod_i   (prod2),
    .byp_en_i (cmd_q3 == CMD_PROD),
    .byp_i    (byp_q3),
    .r_o      (r2)
  );

  assign out_rsp_o.r_w = r2[C_W];
  assign out_rsp_o.r_x = r2[C_X];
  assign out_rsp_o.r_y = r2[C_Y];
  assign out_rsp_o.r_z = r2[C_Z];

  // accepted request lands in stage 1
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v1_q)
    else $error("accepted request missing from stage 1");

  // with the output stalled, input backs up only when every stage is full
  a_backup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && !out_ready_i |-> (in_ready_o == !(v1_q && v2_q && v3_q)))
    else $error("input ready disagrees with pipeline occupancy");

  // product request carries its a*b straight to the output
  a_bypass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && en4 && (cmd_q3 == CMD_PROD) |=> (out_rsp_o.r_w == $past(byp_q3[C_W]))
      && (out_rsp_o.r_z == $past(byp_q3[C_Z])))
    else $error("product result lost on bypass");

endmodule

`default_nettype wire
